[rtl/jsu_pkg.sv]
// ============================================================================
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ============================================================================
package jsu_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_UNCLOSED    = 3'd0,
        ERR_BAD_ESCAPE  = 3'd1,
        ERR_RAW_CONTROL = 3'd2,
        ERR_BAD_HEX     = 3'd3,
        ERR_LONE_LOW    = 3'd4,
        ERR_MISSING_LOW = 3'd5
    } t_err;

    typedef enum logic [3:0] {
        PH_WAIT    = 4'd0,
        PH_BODY    = 4'd1,
        PH_ESC     = 4'd2,
        PH_HEX1    = 4'd3,
        PH_WANTBSL = 4'd4,
        PH_WANTU   = 4'd5,
        PH_HEX2    = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        JOB_RAW   = 2'd0,
        JOB_CP    = 2'd1,
        JOB_CLOSE = 2'd2,
        JOB_ERR   = 2'd3
    } t_job_op;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        t_err       error_code;
        logic       last_of_run;
    } t_out_beat;

    typedef struct packed {
        t_job_op     op;
        logic [20:0] cp;
        t_err        err;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_q_ctl;

endpackage

[rtl/jsu_front.sv]
// ============================================================================
// jsu_front
// Takes one raw byte per beat, tracks the escape state and emits one job
// (raw byte, code point, close or error) into the queue when there is one.
// ============================================================================
module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsu_pkg::t_in_beat i_in_beat,
    input  logic             i_q_full,
    output logic             o_q_push,
    output jsu_pkg::t_job    o_q_job
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_UC_U  = 8'h55;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    t_phase      r_phase, n_phase;
    logic [11:0] r_hex, n_hex;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_high, n_high;

    logic        accept;
    logic [7:0]  b;
    logic [4:0]  dig;
    logic [15:0] full4;
    logic        emit, err_v, closed;
    t_err        err_c;
    t_job        job;

    assign accept = i_push && !i_q_full;
    assign b      = i_in_beat.in_byte;
    assign dig    = hex_digit(b);
    assign full4  = {r_hex, dig[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_hex   <= '0;
            r_cnt   <= '0;
            r_high  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_cnt   <= n_cnt;
            r_high  <= n_high;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_cnt   = r_cnt;
        n_high  = r_high;
        emit    = 1'b0;
        err_v   = 1'b0;
        err_c   = ERR_UNCLOSED;
        closed  = 1'b0;
        job.op  = JOB_RAW;
        job.cp  = {13'd0, b};
        job.err = ERR_UNCLOSED;

        case (r_phase)
            PH_WAIT: begin
                n_phase = PH_BODY;
            end
            PH_BODY: begin
                if (b == CH_QUOTE) begin
                    closed = 1'b1;
                end else if (b == CH_BSL) begin
                    n_phase = PH_ESC;
                end else if (b inside {CH_TAB, CH_LF, CH_FF, CH_BS, CH_CR}) begin
                    err_v = 1'b1;
                    err_c = ERR_RAW_CONTROL;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_ESC: begin
                n_phase = PH_BODY;
                emit    = 1'b1;
                case (b)
                    CH_QUOTE, CH_BSL, CH_SLASH: job.cp = {13'd0, b};
                    CH_LC_N:  job.cp = {13'd0, CH_LF};
                    CH_LC_R:  job.cp = {13'd0, CH_CR};
                    CH_LC_T:  job.cp = {13'd0, CH_TAB};
                    CH_LC_F:  job.cp = {13'd0, CH_FF};
                    CH_LC_B:  job.cp = {13'd0, CH_BS};
                    CH_LC_U, CH_UC_U: begin
                        emit    = 1'b0;
                        n_phase = PH_HEX1;
                        n_hex   = '0;
                        n_cnt   = '0;
                    end
                    default: begin
                        emit  = 1'b0;
                        err_v = 1'b1;
                        err_c = ERR_BAD_ESCAPE;
                    end
                endcase
            end
            PH_HEX1, PH_HEX2: begin
                if (!dig[4]) begin
                    err_v = 1'b1;
                    err_c = ERR_BAD_HEX;
                end else begin
                    n_hex = full4[11:0];
                    if (r_cnt != 2'd3) begin
                        n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_cnt = '0;
                        if (r_phase == PH_HEX1) begin
                            if (full4[15:10] == 6'b110110) begin
                                n_high  = full4[9:0];
                                n_phase = PH_WANTBSL;
                            end else if (full4[15:10] == 6'b110111) begin
                                err_v = 1'b1;
                                err_c = ERR_LONE_LOW;
                            end else begin
                                emit    = 1'b1;
                                job.op  = JOB_CP;
                                job.cp  = {5'd0, full4};
                                n_phase = PH_BODY;
                            end
                        end else begin
                            if (full4[15:10] == 6'b110111) begin
                                emit    = 1'b1;
                                job.op  = JOB_CP;
                                job.cp  = 21'h10000 + {1'b0, r_high, full4[9:0]};
                                n_phase = PH_BODY;
                            end else begin
                                err_v = 1'b1;
                                err_c = ERR_MISSING_LOW;
                            end
                        end
                    end
                end
            end
            PH_WANTBSL: begin
                if (b == CH_BSL) begin
                    n_phase = PH_WANTU;
                end else begin
                    err_v = 1'b1;
                    err_c = ERR_MISSING_LOW;
                end
            end
            PH_WANTU: begin
                if (b == CH_LC_U) begin
                    n_phase = PH_HEX2;
                    n_hex   = '0;
                    n_cnt   = '0;
                end else begin
                    err_v = 1'b1;
                    err_c = ERR_MISSING_LOW;
                end
            end
            default: begin
                n_phase = PH_BODY;
            end
        endcase

        // text ran out before the string closed
        if (!err_v && !closed && i_in_beat.end_of_text) begin
            err_v = 1'b1;
            if (n_phase == PH_HEX1) begin
                err_c = ERR_BAD_HEX;
            end else if (n_phase == PH_WANTBSL || n_phase == PH_WANTU ||
                         n_phase == PH_HEX2) begin
                err_c = ERR_MISSING_LOW;
            end else begin
                err_c = ERR_UNCLOSED;
            end
        end

        if (err_v) begin
            job.op  = JOB_ERR;
            job.cp  = '0;
            job.err = err_c;
        end else if (closed) begin
            job.op  = JOB_CLOSE;
            job.cp  = '0;
        end

        if (err_v || closed) begin
            n_phase = PH_WAIT;
            n_hex   = '0;
            n_cnt   = '0;
            n_high  = '0;
        end

        o_q_push = accept && (emit || err_v || closed);
        o_q_job  = job;
    end

endmodule

[rtl/jsu_queue.sv]
// ============================================================================
// jsu_queue
// Small register queue of jobs between the front and the back.
// ============================================================================
module jsu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jsu_pkg::t_job  i_job,
    input  logic           i_pop,
    output jsu_pkg::t_job  o_head,
    output jsu_pkg::t_q_ctl o_ctl
);
    import jsu_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;
    logic           full, empty, do_push, do_pop;

    assign full    = (r_count == (QAW+1)'(QDEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_head      = r_mem[r_rd];
    assign o_ctl.push  = do_push;
    assign o_ctl.pop   = do_pop;
    assign o_ctl.full  = full;
    assign o_ctl.empty = empty;

endmodule

[rtl/jsu_back.sv]
// ============================================================================
// jsu_back
// Expands the head job into result beats (UTF-8 bytes one per cycle while
// popped) and holds each beat in the output register until it is popped.
// ============================================================================
module jsu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jsu_pkg::t_job     i_head,
    input  logic              i_head_valid,
    output logic              o_head_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output jsu_pkg::t_out_beat o_out_beat
);
    import jsu_pkg::*;

    // index of the last UTF-8 byte
    function automatic logic [1:0] utf8_last(input logic [20:0] cp);
        logic [1:0] r;
        if (cp[20:16] != '0) begin
            r = 2'd3;
        end else if (cp[15:11] != '0) begin
            r = 2'd2;
        end else if (cp[10:7] != '0) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len,
                                             input logic [1:0] idx);
        logic [7:0] r;
        r = cp[7:0];
        case (len)
            2'd0: r = cp[7:0];
            2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2: begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return r;
    endfunction

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out, n_out;
    logic [1:0] last_idx;
    logic       load, is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        last_idx = (i_head.op == JOB_CP) ? utf8_last(i_head.cp) : 2'd0;
        is_last  = (r_idx == last_idx);
        load     = i_head_valid && (!r_out_valid || i_pop);

        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;

        if (load) begin
            n_out_valid       = 1'b1;
            n_out.last_of_run = is_last;
            n_out.out_byte    = '0;
            n_out.kind        = KIND_BYTE;
            n_out.error_code  = ERR_UNCLOSED;
            case (i_head.op)
                JOB_RAW:   n_out.out_byte = i_head.cp[7:0];
                JOB_CP:    n_out.out_byte = utf8_byte(i_head.cp, last_idx, r_idx);
                JOB_CLOSE: n_out.kind = KIND_CLOSE;
                default: begin
                    n_out.kind       = KIND_ERROR;
                    n_out.error_code = i_head.err;
                end
            endcase
            n_idx = is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_head_pop = load && is_last;
    assign o_empty    = !r_out_valid;
    assign o_out_beat = r_out;

endmodule

[rtl/json_string_unescape_utf8.sv]
// ============================================================================
// json_string_unescape_utf8
// Unescapes a quoted JSON string into UTF-8 bytes with close and error beats.
// ============================================================================
// Input channel: one raw text byte per beat (push/full), the opening quote
// first; end_of_text marks the last byte available.
// Result channel: queue-like (empty/pop). Each beat is a decoded byte, a
// string-closed mark or an error; last_of_run flags the final beat caused
// by one input byte. Opening quote, backslash and partial hex digits give
// no beat.
// Path: each job is registered in the job queue, each result beat in the output register.
// Throughput: one input byte per cycle while full is low; one result beat
// per cycle while the receiver pops. A \u escape gives up to three bytes,
// a surrogate pair four, sent by the back end while the job queue takes input.
// Reset: synchronous; returns to waiting for an opening quote and empties
// the queue and the output register.
// When the receiver stalls, the output register holds its beat, the job
// queue fills, and full rises once four jobs are waiting.
// After a close or an error the next byte is taken as a new opening quote.
// ============================================================================
module json_string_unescape_utf8 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  jsu_pkg::t_in_beat  i_in_beat,
    output logic               empty,
    input  logic               pop,
    output jsu_pkg::t_out_beat o_out_beat
);
    import jsu_pkg::*;

    logic   q_push;
    t_job   q_job, q_head;
    t_q_ctl q_ctl;
    logic   head_pop;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_beat (i_in_beat),
        .i_q_full  (q_ctl.full),
        .o_q_push  (q_push),
        .o_q_job   (q_job)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (head_pop),
        .o_head  (q_head),
        .o_ctl   (q_ctl)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (!q_ctl.empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_beat   (o_out_beat)
    );

    assign full = q_ctl.full;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_mark_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_beat.kind != KIND_BYTE) |-> o_out_beat.last_of_run)
        else $error("close or error beat not last of run");

    a_mark_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_beat.kind != KIND_BYTE) |-> o_out_beat.out_byte == 8'd0)
        else $error("close or error beat carries a byte");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_beat.kind != KIND_ERROR) |-> o_out_beat.error_code == ERR_UNCLOSED)
        else $error("error code set on non-error beat");

endmodule

[dv/jsu_unescape_checker.sv]
// ============================================================================
// jsu_unescape_checker
// Predicts and checks the UTF-8 unescaper result beats.
// ============================================================================
// Watches both channels of the block. Every accepted text byte runs through
// a local copy of the unescape state machine, which appends the beats the
// byte causes to a due list. Every accepted result beat is compared field by
// field with the oldest due beat. The failure count and the number of beats
// still due go to the testbench top.
// ============================================================================
module jsu_unescape_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  jsu_pkg::t_in_beat   i_in_beat,
    input  logic                i_empty,
    input  logic                i_pop,
    input  jsu_pkg::t_out_beat  i_out_beat,
    output int                  o_fail_count,
    output int                  o_pending
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_UC_U  = 8'h55;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam int         MAX_PRINTS = 40;

    t_phase      str_phase;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [9:0]  hi_half;
    t_out_beat   utf8_beats_due[$];
    t_out_beat   byte_beats[$];

    function automatic int hex_digit(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
        if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
        if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
        return -1;
    endfunction

    task automatic restart_string();
        str_phase = PH_WAIT;
        hex_acc   = '0;
        hex_cnt   = '0;
        hi_half   = '0;
    endtask

    task automatic append_beat(logic [7:0] v, t_kind k, t_err e);
        t_out_beat bt;
        bt.out_byte    = v;
        bt.kind        = k;
        bt.error_code  = e;
        bt.last_of_run = 1'b0;
        byte_beats.insert(byte_beats.size(), bt);
    endtask

    task automatic push_data(logic [7:0] v);
        append_beat(v, KIND_BYTE, ERR_UNCLOSED);
    endtask

    task automatic push_utf8(logic [20:0] cp);
        if (cp <= 21'h7F) begin
            push_data(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            push_data(8'hC0 | cp[10:6]);
            push_data(8'h80 | cp[5:0]);
        end else if (cp <= 21'hFFFF) begin
            push_data(8'hE0 | cp[15:12]);
            push_data(8'h80 | cp[11:6]);
            push_data(8'h80 | cp[5:0]);
        end else begin
            push_data(8'hF0 | cp[20:18]);
            push_data(8'h80 | cp[17:12]);
            push_data(8'h80 | cp[11:6]);
            push_data(8'h80 | cp[5:0]);
        end
    endtask

    task automatic unescape_byte(logic [7:0] b, logic eot);
        bit        err_hit;
        bit        closed;
        t_err      err;
        int        hv;
        t_out_beat tail;
        err_hit = 1'b0;
        closed  = 1'b0;
        err     = ERR_UNCLOSED;
        byte_beats.delete();
        case (str_phase)
            PH_WAIT: str_phase = PH_BODY;
            PH_BODY: begin
                if (b == CH_QUOTE) begin
                    closed = 1'b1;
                end else if (b == CH_BSL) begin
                    str_phase = PH_ESC;
                end else if (b == CH_TAB || b == CH_LF || b == CH_FF || b == CH_BS ||
                             b == CH_CR) begin
                    err_hit = 1'b1;
                    err     = ERR_RAW_CONTROL;
                end else begin
                    push_data(b);
                end
            end
            PH_ESC: begin
                str_phase = PH_BODY;
                case (b)
                    CH_QUOTE, CH_BSL, CH_SLASH: push_data(b);
                    CH_N: push_data(CH_LF);
                    CH_R: push_data(CH_CR);
                    CH_T: push_data(CH_TAB);
                    CH_F: push_data(CH_FF);
                    CH_B: push_data(CH_BS);
                    CH_LC_U, CH_UC_U: begin
                        str_phase = PH_HEX1;
                        hex_acc   = '0;
                        hex_cnt   = '0;
                    end
                    default: begin
                        err_hit = 1'b1;
                        err     = ERR_BAD_ESCAPE;
                    end
                endcase
            end
            PH_HEX1, PH_HEX2: begin
                hv = hex_digit(b);
                if (hv < 0) begin
                    err_hit = 1'b1;
                    err     = ERR_BAD_HEX;
                end else begin
                    hex_acc = {hex_acc[11:0], hv[3:0]};
                    if (hex_cnt != 2'd3) begin
                        hex_cnt = hex_cnt + 2'd1;
                    end else begin
                        hex_cnt = '0;
                        if (str_phase == PH_HEX1) begin
                            if (hex_acc >= 16'hD800 && hex_acc < 16'hDC00) begin
                                hi_half   = hex_acc[9:0];
                                str_phase = PH_WANTBSL;
                            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                                err_hit = 1'b1;
                                err     = ERR_LONE_LOW;
                            end else begin
                                push_utf8({5'd0, hex_acc});
                                str_phase = PH_BODY;
                            end
                        end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                            push_utf8(21'h10000 + {1'b0, hi_half, hex_acc[9:0]});
                            str_phase = PH_BODY;
                        end else begin
                            err_hit = 1'b1;
                            err     = ERR_MISSING_LOW;
                        end
                    end
                end
            end
            PH_WANTBSL: begin
                if (b == CH_BSL) begin
                    str_phase = PH_WANTU;
                end else begin
                    err_hit = 1'b1;
                    err     = ERR_MISSING_LOW;
                end
            end
            PH_WANTU: begin
                if (b == CH_LC_U) begin
                    str_phase = PH_HEX2;
                    hex_acc   = '0;
                    hex_cnt   = '0;
                end else begin
                    err_hit = 1'b1;
                    err     = ERR_MISSING_LOW;
                end
            end
            default: str_phase = PH_BODY;
        endcase

        // text ran out before the string closed
        if (!err_hit && !closed && eot) begin
            err_hit = 1'b1;
            case (str_phase)
                PH_HEX1: err = ERR_BAD_HEX;
                PH_WANTBSL, PH_WANTU, PH_HEX2: err = ERR_MISSING_LOW;
                default: err = ERR_UNCLOSED;
            endcase
        end

        if (err_hit) begin
            byte_beats.delete();
            append_beat(8'h00, KIND_ERROR, err);
            restart_string();
        end else if (closed) begin
            append_beat(8'h00, KIND_CLOSE, ERR_UNCLOSED);
            restart_string();
        end

        if (byte_beats.size() > 0) begin
            tail = byte_beats[byte_beats.size() - 1];
            tail.last_of_run = 1'b1;
            byte_beats[byte_beats.size() - 1] = tail;
        end
        foreach (byte_beats[i]) utf8_beats_due.insert(utf8_beats_due.size(), byte_beats[i]);
    endtask

    task automatic report_mismatch(string what, logic [15:0] want_v, logic [15:0] got_v);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s expected %0h got %0h", $time, what, want_v, got_v);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_beat want;
        if (!i_rst_n) begin
            restart_string();
            utf8_beats_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (utf8_beats_due.size() == 0) begin
                    report_mismatch("beat with nothing due", 16'h0, 16'(i_out_beat));
                end else begin
                    want = utf8_beats_due.pop_front();
                    if (i_out_beat.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 16'(want.out_byte),
                                        16'(i_out_beat.out_byte));
                    if (i_out_beat.kind !== want.kind)
                        report_mismatch("kind", 16'(want.kind), 16'(i_out_beat.kind));
                    if (i_out_beat.error_code !== want.error_code)
                        report_mismatch("error_code", 16'(want.error_code),
                                        16'(i_out_beat.error_code));
                    if (i_out_beat.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 16'(want.last_of_run),
                                        16'(i_out_beat.last_of_run));
                end
            end
            if (i_push && !i_full)
                unescape_byte(i_in_beat.in_byte, i_in_beat.end_of_text);
        end
        o_pending <= utf8_beats_due.size();
    end

endmodule

[dv/tb_json_string_unescape_utf8.sv]
// ============================================================================
// tb_json_string_unescape_utf8
// Stimulus and verdict for the JSON string unescaper.
// ============================================================================
// Feeds short quoted strings, a few fixed ones first and then random ones:
// plain bytes, simple escapes, \u escapes from one to three UTF-8 bytes and
// surrogate pairs, plus broken escapes, raw control bytes, bad hex and text
// that ends early. Both sides pause at random; once the reader stops for a
// long stretch so the block backs up. A side checker predicts and compares.
// ============================================================================
module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int N_RANDOM     = 420;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_LC_U  = 8'h75;
    localparam logic [7:0] CH_UC_U  = 8'h55;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum int {
        BC_PLAIN,
        BC_BAD_ESC,
        BC_NON_HEX,
        BC_NON_BSL,
        BC_NON_LC_U
    } t_byte_class;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic       empty;
    logic       pop;
    t_in_beat   in_beat;
    t_out_beat  out_beat;
    int         fail_count;
    int         pending;
    int         sent_count = 0;
    int         idle_cycles = 0;
    bit         sender_quiet = 1'b0;
    bit         receiver_quiet = 1'b0;
    bit         hold_done = 1'b0;
    logic [7:0] text[$];

    always #5 i_clk = ~i_clk;

    json_string_unescape_utf8 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_beat  (in_beat),
        .empty      (empty),
        .pop        (pop),
        .o_out_beat (out_beat)
    );

    jsu_unescape_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_beat    (in_beat),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_beat   (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic void text_add(logic [7:0] b);
        text.insert(text.size(), b);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 4'd10) return 8'h30 + {4'd0, d};
        return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + {4'd0, d} - 8'd10;
    endfunction

    function automatic logic [7:0] pick_byte(t_byte_class cls);
        logic [7:0] b;
        bit         ok;
        do begin
            b = 8'($urandom_range(0, 255));
            case (cls)
                BC_PLAIN: ok = b != CH_QUOTE && b != CH_BSL && b != CH_TAB && b != CH_LF &&
                               b != CH_FF && b != CH_BS && b != CH_CR;
                BC_BAD_ESC: ok = b != CH_QUOTE && b != CH_BSL && b != CH_SLASH && b != CH_N &&
                                 b != CH_R && b != CH_T && b != CH_F && b != CH_B &&
                                 b != CH_LC_U && b != CH_UC_U;
                BC_NON_HEX: ok = !((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
                                   (b >= 8'h41 && b <= 8'h46));
                BC_NON_BSL: ok = b != CH_BSL;
                default: ok = b != CH_LC_U;
            endcase
        end while (!ok);
        return b;
    endfunction

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) text_add(s[i]);
    endtask

    task automatic add_u(logic [15:0] v, bit upper);
        text_add(CH_BSL);
        text_add(upper ? CH_UC_U : CH_LC_U);
        for (int i = 3; i >= 0; i--) text_add(hex_char(v[4*i +: 4]));
    endtask

    task automatic add_partial_hex();
        repeat ($urandom_range(0, 3)) text_add(hex_char(4'($urandom_range(0, 15))));
        text_add(pick_byte(BC_NON_HEX));
    endtask

    task automatic add_token();
        logic [20:0] cp;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: text_add(pick_byte(BC_PLAIN));
            4, 5: begin
                text_add(CH_BSL);
                case ($urandom_range(0, 7))
                    0: text_add(CH_QUOTE);
                    1: text_add(CH_BSL);
                    2: text_add(CH_SLASH);
                    3: text_add(CH_N);
                    4: text_add(CH_R);
                    5: text_add(CH_T);
                    6: text_add(CH_F);
                    default: text_add(CH_B);
                endcase
            end
            default: begin
                case ($urandom_range(0, 5))
                    0: cp = 21'($urandom_range(0, 'h7F));
                    1: cp = 21'($urandom_range('h80, 'h7FF));
                    2: do cp = 21'($urandom_range('h800, 'hFFFF));
                        while (cp >= 21'hD800 && cp <= 21'hDFFF);
                    3: cp = 21'($urandom_range('h10000, 'h10FFFF));
                    default: begin
                        case ($urandom_range(0, 9))
                            0: cp = 21'h0;
                            1: cp = 21'h7F;
                            2: cp = 21'h80;
                            3: cp = 21'h7FF;
                            4: cp = 21'h800;
                            5: cp = 21'hD7FF;
                            6: cp = 21'hE000;
                            7: cp = 21'hFFFF;
                            8: cp = 21'h10000;
                            default: cp = 21'h10FFFF;
                        endcase
                    end
                endcase
                if (cp >= 21'h10000) begin
                    add_u(16'hD800 + 16'((cp - 21'h10000) >> 10), 1'($urandom_range(0, 1)));
                    add_u(16'hDC00 + {6'd0, cp[9:0]}, 1'b0);
                end else begin
                    add_u(cp[15:0], 1'($urandom_range(0, 1)));
                end
            end
        endcase
    endtask

    task automatic add_error();
        logic [15:0] hi;
        logic [15:0] v;
        hi = 16'hD800 + 16'($urandom_range(0, 'h3FF));
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0: text_add(CH_TAB);
                    1: text_add(CH_LF);
                    2: text_add(CH_FF);
                    3: text_add(CH_BS);
                    default: text_add(CH_CR);
                endcase
            end
            1: begin
                text_add(CH_BSL);
                text_add(pick_byte(BC_BAD_ESC));
            end
            2: begin
                text_add(CH_BSL);
                text_add(($urandom_range(0, 1) == 1) ? CH_UC_U : CH_LC_U);
                add_partial_hex();
            end
            3: add_u(16'hDC00 + 16'($urandom_range(0, 'h3FF)), 1'($urandom_range(0, 1)));
            4: begin
                add_u(hi, 1'($urandom_range(0, 1)));
                text_add(pick_byte(BC_NON_BSL));
            end
            5: begin
                add_u(hi, 1'($urandom_range(0, 1)));
                text_add(CH_BSL);
                text_add(($urandom_range(0, 1) == 1) ? CH_UC_U : pick_byte(BC_NON_LC_U));
            end
            6: begin
                add_u(hi, 1'($urandom_range(0, 1)));
                do v = 16'($urandom_range(0, 'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
                add_u(v, 1'b0);
            end
            default: begin
                add_u(hi, 1'($urandom_range(0, 1)));
                text_add(CH_BSL);
                text_add(CH_LC_U);
                add_partial_hex();
            end
        endcase
    endtask

    task automatic send_byte(logic [7:0] b, logic eot);
        int gap;
        if ($urandom_range(0, 29) == 0) sender_quiet = !sender_quiet;
        gap = sender_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push    <= 1'b1;
        in_beat <= '{in_byte: b, end_of_text: eot};
        do @(posedge i_clk); while (full);
        sent_count++;
    endtask

    // sends the text, stopping after the byte that carries end_of_text
    task automatic send_text(int eot_idx);
        foreach (text[i]) begin
            send_byte(text[i], i == eot_idx);
            if (i == eot_idx) break;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** json_string_unescape_utf8: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : reader
        int gap;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 29) == 0) receiver_quiet = !receiver_quiet;
            gap = receiver_quiet ? 0 : $urandom_range(0, 18);
            // one long stall so the job queue fills and full rises
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin : stimulus
        int random_base;
        int ending;
        int eot_idx;
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        in_beat <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // byte extremes and a simple escape
        text.delete();
        text_add(CH_QUOTE);
        text_add(8'h00);
        text_add(8'hFF);
        put_str("\\n\"");
        send_text(-1);
        // surrogate pair to four bytes, close wins over end_of_text
        text.delete();
        put_str("\"\\UD83D\\ude00\"");
        send_text(text.size() - 1);
        // raw control byte in the body
        text.delete();
        text_add(CH_QUOTE);
        text_add(CH_TAB);
        send_text(-1);
        // text ends on the opening quote
        text.delete();
        text_add(CH_QUOTE);
        send_text(0);

        random_base = sent_count;
        while (sent_count - random_base < N_RANDOM) begin
            text.delete();
            text_add(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CH_QUOTE);
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5))
                add_token();
            ending  = $urandom_range(0, 19);
            eot_idx = -1;
            if (ending < 11) begin
                text_add(CH_QUOTE);
                if ($urandom_range(0, 3) == 0) eot_idx = text.size() - 1;
            end else if (ending < 17) begin
                add_error();
                if ($urandom_range(0, 1) == 0) eot_idx = text.size() - 1;
            end else begin
                text_add(CH_QUOTE);
                eot_idx = $urandom_range(0, text.size() - 1);
            end
            send_text(eot_idx);
        end
        push <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** json_string_unescape_utf8: PASSED **");
        end else begin
            $display("** json_string_unescape_utf8: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
dv/jsu_unescape_checker.sv
dv/tb_json_string_unescape_utf8.sv
